### sv/spq_pkg.sv
// shared types, codes and defaults for the sorted priority queue
`default_nettype none
package spq_pkg;

	localparam int SPQ_DEPTH = 8;
	localparam int DATA_W    = 32;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ_RD,
		ST_ENQ_CMP,
		ST_ENQ_HEAD,
		ST_DEQ_RD,
		ST_DEQ_WR,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### sv/spq_in_if.sv
// request channel: operation word with value and priority
`default_nettype none
interface spq_in_if;
	import spq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] item_priority;

	modport source (output valid, action, item_value, item_priority, input ready);
	modport sink   (input valid, action, item_value, item_priority, output ready);
endinterface
`default_nettype wire

### sv/spq_out_if.sv
// result channel: status, removed entry, head peek and count
`default_nettype none
interface spq_out_if;
	import spq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] removed_value;
	logic signed [DATA_W-1:0] removed_priority;
	logic                     head_valid;
	logic signed [DATA_W-1:0] head_value;
	logic signed [DATA_W-1:0] head_priority;
	logic [3:0]               entry_count;

	modport source (output valid, status, removed_value, removed_priority, head_valid,
		head_value, head_priority, entry_count, input ready);
	modport sink   (input valid, status, removed_value, removed_priority, head_valid,
		head_value, head_priority, entry_count, output ready);
endinterface
`default_nettype wire

### sv/spq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module spq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### sv/sorted_priority_queue.sv
// sorted priority queue top level: sequencer around the entry ram
//
// req carries one operation word: action 0 enqueues (item_value, item_priority),
// action 1 dequeues the head. rsp returns one word per operation with a status
// (done, full, empty), the removed entry on a dequeue, the head entry and the
// count after the operation.
// entries live in one ram kept in ascending priority order; equal priorities
// keep arrival order. a register mirrors the head entry.
// an enqueue walks from the tail toward the head; for each entry compared it
// reads the ram, then compares and writes back: the entry moves up one slot,
// or the new entry lands behind it. an enqueue into an empty queue is written
// straight from idle; a new entry that passes every entry becomes the head in
// a final write of slot 0. a dequeue moves every remaining entry down one slot,
// reading each and writing it back. rejects and single-entry dequeues need no walk.
// req is taken only while the sequencer is idle; a finished word waits in the
// rsp register, and while rsp stalls the next request is still taken and
// worked, then held until the register frees.
// reset clears the state, the count and the response valid flag; ram contents need none.
`default_nettype none
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	spq_in_if.sink   req,
	spq_out_if.source rsp
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t         state_q, state_d;
	logic [AW-1:0]  idx_q;
	logic [CW-1:0]  count_q;
	entry_t         new_q, head_q, rem_q;
	status_t        status_q;
	logic           out_valid_q;

	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	entry_t         ram_wdata, ram_rdata;

	logic           accept, out_free, less, deq_last, is_full, is_empty;
	entry_t         req_entry;

	spq_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign req_entry = '{value: req.item_value, prio: req.item_priority};
	assign less      = new_q.prio < ram_rdata.prio;
	assign deq_last  = CW'(idx_q) == count_q - CW'(1);
	assign is_full   = count_q >= CW'(DEPTH);
	assign is_empty  = count_q == '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.action == ACT_ENQ) begin
						state_d = (is_full || is_empty) ? ST_DONE : ST_ENQ_RD;
					end else begin
						state_d = (count_q <= CW'(1)) ? ST_DONE : ST_DEQ_RD;
					end
				end
			end
			ST_ENQ_RD: state_d = ST_ENQ_CMP;
			ST_ENQ_CMP: begin
				if (less) begin
					state_d = (idx_q == '0) ? ST_ENQ_HEAD : ST_ENQ_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ENQ_HEAD: state_d = ST_DONE;
			ST_DEQ_RD: state_d = ST_DEQ_WR;
			ST_DEQ_WR: state_d = deq_last ? ST_DONE : ST_DEQ_RD;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = new_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.action == ACT_ENQ && is_empty) begin
					ram_we    = 1'b1;
					ram_wdata = req_entry;
				end
			end
			ST_ENQ_RD, ST_DEQ_RD: ram_re = 1'b1;
			ST_ENQ_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q + AW'(1);
				ram_wdata = less ? ram_rdata : new_q;
			end
			ST_ENQ_HEAD: ram_we = 1'b1;
			ST_DEQ_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q - AW'(1);
				ram_wdata = ram_rdata;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.action == ACT_ENQ) begin
							if (!is_full && is_empty) begin
								count_q <= CW'(1);
							end
						end else if (count_q == CW'(1)) begin
							count_q <= '0;
						end
					end
				end
				ST_ENQ_CMP: begin
					if (!less) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_ENQ_HEAD: count_q <= count_q + CW'(1);
				ST_DEQ_WR: begin
					if (deq_last) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: count_q <= count_q;
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					new_q    <= req_entry;
					rem_q    <= '0;
					status_q <= STATUS_DONE;
					if (req.action == ACT_ENQ) begin
						if (is_full) begin
							status_q <= STATUS_FULL;
						end else if (is_empty) begin
							head_q <= req_entry;
						end else begin
							idx_q <= AW'(count_q - CW'(1));
						end
					end else begin
						if (is_empty) begin
							status_q <= STATUS_EMPTY;
						end else begin
							rem_q <= head_q;
							idx_q <= AW'(1);
						end
					end
				end
			end
			ST_ENQ_CMP: begin
				if (less && idx_q != '0) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			ST_ENQ_HEAD: head_q <= new_q;
			ST_DEQ_WR: begin
				if (idx_q == AW'(1)) begin
					head_q <= ram_rdata;
				end
				if (!deq_last) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp.status           <= status_q;
					rsp.removed_value    <= rem_q.value;
					rsp.removed_priority <= rem_q.prio;
					rsp.head_valid       <= !is_empty;
					rsp.head_value       <= is_empty ? '0 : head_q.value;
					rsp.head_priority    <= is_empty ? '0 : head_q.prio;
					rsp.entry_count      <= 4'(count_q);
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	assign rsp.valid = out_valid_q;
endmodule
`default_nettype wire

### tb/testbench.sv
// testbench for sorted_priority_queue: directed corners, fill/drain rounds, random churn and back-to-back churn
`timescale 1ns / 100ps
module testbench;
	import spq_pkg::*;

	localparam logic signed [DATA_W-1:0] P_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] P_MIN = 32'sh8000_0000;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] removed_value;
		logic signed [DATA_W-1:0] removed_priority;
		logic                     head_valid;
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] head_priority;
		logic [3:0]               entry_count;
	} rsp_word_t;

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   fails;

	entry_t    shadow_entries[$];
	rsp_word_t predicted_rsp[$];

	spq_in_if  req_if ();
	spq_out_if rsp_if ();

	sorted_priority_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#5_000_000;
		$display("sorted_priority_queue verification failed");
		$finish;
	end

	// sorted insert after equal priorities, pop from the head
	function automatic rsp_word_t apply_queue_op(logic act, logic signed [DATA_W-1:0] value,
			logic signed [DATA_W-1:0] prio);
		rsp_word_t r;
		entry_t    e;
		int        pos;
		r = '0;
		r.status = STATUS_DONE;
		if (act == ACT_ENQ) begin
			if (shadow_entries.size() >= SPQ_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_entries.size() && !(prio < shadow_entries[pos].prio))
					pos++;
				e.value = value;
				e.prio  = prio;
				shadow_entries.insert(pos, e);
			end
		end else if (shadow_entries.size() == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			e = shadow_entries.pop_front();
			r.removed_value    = e.value;
			r.removed_priority = e.prio;
		end
		if (shadow_entries.size() > 0) begin
			r.head_valid    = 1'b1;
			r.head_value    = shadow_entries[0].value;
			r.head_priority = shadow_entries[0].prio;
		end
		r.entry_count = 4'(shadow_entries.size());
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_prio();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(6) - 3;
			2: return $urandom_range(1) ? P_MAX - $urandom_range(2) : P_MIN + $urandom_range(2);
			default: return $urandom_range(1) ? -1 : 0;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return P_MAX;
			1: return P_MIN;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(logic act, logic signed [DATA_W-1:0] value,
			logic signed [DATA_W-1:0] prio);
		rsp_word_t r;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 37) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.action        <= act;
		req_if.item_value    <= value;
		req_if.item_priority <= prio;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		r = apply_queue_op(act, value, prio);
		predicted_rsp.push_back(r);
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (predicted_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fails++;
		end
	endtask

	always @(negedge clk)
		rsp_if.ready <= no_idle || ($urandom_range(99) >= 37);

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (predicted_rsp.size() == 0) begin
				$error("result word with nothing outstanding");
				fails++;
			end else begin
				want = predicted_rsp.pop_front();
				check_field("status", 32'(want.status), 32'(rsp_if.status));
				check_field("removed_value", want.removed_value, rsp_if.removed_value);
				check_field("removed_priority", want.removed_priority,
					rsp_if.removed_priority);
				check_field("head_valid", 32'(want.head_valid), 32'(rsp_if.head_valid));
				check_field("head_value", want.head_value, rsp_if.head_value);
				check_field("head_priority", want.head_priority, rsp_if.head_priority);
				check_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
			end
		end
	end

	// empty reject, extremes, ties in arrival order, full reject, drain past empty
	task automatic test_directed_corners();
		push_op(ACT_DEQ, $urandom, $urandom);
		push_op(ACT_ENQ, P_MAX, P_MAX);
		push_op(ACT_ENQ, P_MIN, P_MIN);
		push_op(ACT_ENQ, 0, 0);
		push_op(ACT_ENQ, -1, -1);
		push_op(ACT_ENQ, 1, 0);
		push_op(ACT_ENQ, 2, 0);
		push_op(ACT_ENQ, -2, P_MAX);
		push_op(ACT_ENQ, 3, P_MIN);
		push_op(ACT_ENQ, 32'sh1234_5678, -5);
		repeat (SPQ_DEPTH)
			push_op(ACT_DEQ, $urandom, $urandom);
		push_op(ACT_DEQ, P_MAX, P_MIN);
	endtask

	task automatic test_fill_drain_rounds(int rounds);
		int  fill;
		int  drain;
		bit  narrow;
		repeat (rounds) begin
			fill   = $urandom_range(1, SPQ_DEPTH + 2);
			narrow = $urandom_range(1);
			repeat (fill)
				push_op(ACT_ENQ, pick_value(),
					narrow ? 32'($urandom_range(4)) - 2 : pick_prio());
			drain = shadow_entries.size() + $urandom_range(0, 2);
			repeat (drain)
				push_op(ACT_DEQ, $urandom, $urandom);
		end
	endtask

	task automatic test_random_churn(int n);
		int pct;
		repeat (n) begin
			pct = 15 + shadow_entries.size() * 70 / SPQ_DEPTH;
			if ($urandom_range(99) < pct)
				push_op(ACT_DEQ, $urandom, $urandom);
			else
				push_op(ACT_ENQ, pick_value(), pick_prio());
		end
	endtask

	task automatic test_back_to_back(int n);
		no_idle = 1'b1;
		test_random_churn(n);
		no_idle = 1'b0;
	endtask

	initial begin
		fails                = 0;
		no_idle              = 1'b0;
		arst_n               = 1'b0;
		req_if.valid         = 1'b0;
		req_if.action        = ACT_ENQ;
		req_if.item_value    = '0;
		req_if.item_priority = '0;
		rsp_if.ready         = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_corners();
		wait_all_results();
		test_fill_drain_rounds(60);
		wait_all_results();
		test_random_churn(650);
		test_back_to_back(300);
		wait_all_results();
		repeat (50)
			@(posedge clk);

		if (fails == 0 && predicted_rsp.size() == 0)
			$display("sorted_priority_queue verification clean");
		else
			$display("sorted_priority_queue verification failed");
		$finish;
	end

endmodule
